### hdl/hsv_to_rgb_converter_assert.svh
// assertion macros shared by the hsv to rgb converter checker
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define HSV2RGB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsv2rgb check failed");

// next-cycle implication, disabled while in reset
`define HSV2RGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsv2rgb check failed");

`endif

### hdl/hsv2rgb_pkg.sv
// shared types, constants and helpers of the hsv to rgb converter
`default_nettype none

package hsv2rgb_pkg;

   localparam int unsigned HUE_W  = 16;
   localparam int unsigned FRAC_W = 9;
   localparam int unsigned CHAN_W = 8;
   localparam int unsigned PROD_W = 17;
   localparam int unsigned POS_W  = 12;
   localparam int unsigned TERM_W = 28;

   localparam logic [HUE_W-1:0]  HUE_FULL     = 16'd23040;
   localparam logic [POS_W-1:0]  HUE_SECTOR   = 12'd3840;
   localparam logic [FRAC_W-1:0] FRAC_ONE     = 9'd256;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // 60 degree sectors
   localparam logic [2:0] SEC_RED_YEL = 3'd0;
   localparam logic [2:0] SEC_YEL_GRN = 3'd1;
   localparam logic [2:0] SEC_GRN_CYN = 3'd2;
   localparam logic [2:0] SEC_CYN_BLU = 3'd3;
   localparam logic [2:0] SEC_BLU_MAG = 3'd4;
   localparam logic [2:0] SEC_MAG_RED = 3'd5;

   typedef struct packed {
      logic              valid;
      logic              in_range;
      logic [2:0]        sector;
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] val_q;
      logic [POS_W-1:0]  pos;
   } s1_type;

   typedef struct packed {
      logic              valid;
      logic [TERM_W-1:0] red;
      logic [TERM_W-1:0] green;
      logic [TERM_W-1:0] blue;
   } term_type;

   // start of a sector in hue units
   function automatic logic [14:0] sector_base(input logic [2:0] sector);
      logic [14:0] base;
      case (sector)
         SEC_RED_YEL: base = 15'd0;
         SEC_YEL_GRN: base = 15'd3840;
         SEC_GRN_CYN: base = 15'd7680;
         SEC_CYN_BLU: base = 15'd11520;
         SEC_BLU_MAG: base = 15'd15360;
         default:     base = 15'd19200;
      endcase
      return base;
   endfunction

   // term * 255 / (65536 * 3840) reduces to term * 17 / 2^24
   function automatic logic [CHAN_W-1:0] scale_chan(input logic [TERM_W-1:0] term);
      logic [32:0] prod;
      prod = {1'b0, term, 4'b0000} + {5'b00000, term};
      return prod[31:24];
   endfunction

endpackage

`default_nettype wire

### hdl/hsv2rgb_sector.sv
// first stage: clamp fractions, find the hue sector and form v*s
`default_nettype none

module hsv2rgb_sector
   import hsv2rgb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [HUE_W-1:0]  hue,
   input  wire logic [FRAC_W-1:0] sat,
   input  wire logic [FRAC_W-1:0] val,
   output s1_type                 s1
);

   s1_type            s1_ff;
   s1_type            s1_in;
   logic [FRAC_W-1:0] sat_c;
   logic [FRAC_W-1:0] val_c;
   logic [2:0]        sector;
   logic [14:0]       pos_full;
   logic [POS_W-1:0]  pos;
   logic [17:0]       prod_full;

   always_comb begin
      sat_c = (sat > FRAC_ONE) ? FRAC_ONE : sat;
      val_c = (val > FRAC_ONE) ? FRAC_ONE : val;

      if (hue >= 16'd19200) begin
         sector = SEC_MAG_RED;
      end else if (hue >= 16'd15360) begin
         sector = SEC_BLU_MAG;
      end else if (hue >= 16'd11520) begin
         sector = SEC_CYN_BLU;
      end else if (hue >= 16'd7680) begin
         sector = SEC_GRN_CYN;
      end else if (hue >= 16'd3840) begin
         sector = SEC_YEL_GRN;
      end else begin
         sector = SEC_RED_YEL;
      end

      pos_full  = hue[14:0] - sector_base(sector);
      pos       = pos_full[POS_W-1:0];
      prod_full = 18'(sat_c) * 18'(val_c);

      s1_in.valid    = accept;
      s1_in.in_range = (hue < HUE_FULL);
      s1_in.sector   = sector;
      s1_in.prod     = prod_full[PROD_W-1:0];
      s1_in.val_q    = {val_c, 8'h00};
      // falling ramp in odd sectors
      s1_in.pos      = sector[0] ? (HUE_SECTOR - pos) : pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= s1_in.valid;
      end
      s1_ff.in_range <= s1_in.in_range;
      s1_ff.sector   <= s1_in.sector;
      s1_ff.prod     <= s1_in.prod;
      s1_ff.val_q    <= s1_in.val_q;
      s1_ff.pos      <= s1_in.pos;
   end

   assign s1 = s1_ff;

endmodule

`default_nettype wire

### hdl/hsv2rgb_chroma.sv
// second and third stages: secondary term, offset and per-channel sums
`default_nettype none

module hsv2rgb_chroma
   import hsv2rgb_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire s1_type s1,
   output term_type    terms
);

   logic [28:0]       x_full;
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_in_range_ff, s2_in_range_in;
   logic [2:0]        s2_sector_ff, s2_sector_in;
   logic [TERM_W-1:0] s2_x_ff, s2_x_in;
   logic [PROD_W-1:0] s2_mq_ff, s2_mq_in;
   logic [PROD_W-1:0] s2_vq_ff, s2_vq_in;

   logic [28:0]       tm_w;
   logic [28:0]       tc_w;
   logic [TERM_W-1:0] tm;
   logic [TERM_W-1:0] tc;
   logic [TERM_W-1:0] tx;
   term_type          terms_ff, terms_in;

   // stage two: x = v*s*pos, m and v in q16
   always_comb begin
      x_full         = 29'(s1.prod) * 29'(s1.pos);
      s2_valid_in    = s1.valid;
      s2_in_range_in = s1.in_range;
      s2_sector_in   = s1.sector;
      s2_x_in        = x_full[TERM_W-1:0];
      s2_mq_in       = s1.val_q - s1.prod;
      s2_vq_in       = s1.val_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      s2_in_range_ff <= s2_in_range_in;
      s2_sector_ff   <= s2_sector_in;
      s2_x_ff        <= s2_x_in;
      s2_mq_ff       <= s2_mq_in;
      s2_vq_ff       <= s2_vq_in;
   end

   // stage three: scale by 3840 with shift and subtract, pick per sector
   always_comb begin
      tm_w = {s2_mq_ff, 12'h000} - {4'h0, s2_mq_ff, 8'h00};
      tc_w = {s2_vq_ff, 12'h000} - {4'h0, s2_vq_ff, 8'h00};
      tm   = tm_w[TERM_W-1:0];
      tc   = tc_w[TERM_W-1:0];
      tx   = tm + s2_x_ff;

      terms_in.valid = s2_valid_ff;
      terms_in.red   = tm;
      terms_in.green = tm;
      terms_in.blue  = tm;
      if (s2_in_range_ff) begin
         case (s2_sector_ff)
            SEC_RED_YEL: begin
               terms_in.red   = tc;
               terms_in.green = tx;
            end
            SEC_YEL_GRN: begin
               terms_in.red   = tx;
               terms_in.green = tc;
            end
            SEC_GRN_CYN: begin
               terms_in.green = tc;
               terms_in.blue  = tx;
            end
            SEC_CYN_BLU: begin
               terms_in.green = tx;
               terms_in.blue  = tc;
            end
            SEC_BLU_MAG: begin
               terms_in.red  = tx;
               terms_in.blue = tc;
            end
            default: begin
               terms_in.red  = tc;
               terms_in.blue = tx;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         terms_ff.valid <= 1'b0;
      end else begin
         terms_ff.valid <= terms_in.valid;
      end
      terms_ff.red   <= terms_in.red;
      terms_ff.green <= terms_in.green;
      terms_ff.blue  <= terms_in.blue;
   end

   assign terms = terms_ff;

endmodule

`default_nettype wire

### hdl/hsv2rgb_scale.sv
// last stage: scale channel sums to 8 bits into the output registers
`default_nettype none

module hsv2rgb_scale
   import hsv2rgb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire term_type           terms,
   output logic                    out_valid,
   output logic [CHAN_W-1:0]       out_red,
   output logic [CHAN_W-1:0]       out_green,
   output logic [CHAN_W-1:0]       out_blue
);

   logic              valid_ff, valid_in;
   logic [CHAN_W-1:0] red_ff, red_in;
   logic [CHAN_W-1:0] green_ff, green_in;
   logic [CHAN_W-1:0] blue_ff, blue_in;

   always_comb begin
      valid_in = terms.valid;
      red_in   = scale_chan(terms.red);
      green_in = scale_chan(terms.green);
      blue_in  = scale_chan(terms.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign out_valid = valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule

`default_nettype wire

### hdl/hsv_to_rgb_converter.sv
// top level of the hsv to rgb converter
`default_nettype none

// HSV to RGB pixel converter. One pixel beat is taken on every clock edge at
// which start is high and busy is low; busy is high only while reset is held,
// so a new pixel can enter in every cycle. Each pixel gives exactly one result
// beat, shown on the rsp_ ports with rsp_valid high for a single cycle, after
// it has passed all register stages. The receiver cannot stall the block
// and must take every beat as it appears. There are four register stages:
// clamp, hue sector and the 9x9 v*s multiply; the 17x12 multiply for the
// secondary term; shift-add scaling by 3840 and the per-sector channel
// pick; and the final scale to 8 bits. Hue is in degrees times 64,
// saturation and value are fractions with 256 meaning 1.0 (larger codes
// clamp to 1.0). Hues of 360 degrees or more give grey at the level v*(1-s).
// Alpha is always 255. No state is kept between pixels.

module hsv_to_rgb_converter
   import hsv2rgb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   // pixel in
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [HUE_W-1:0]  req_hue_deg_q6,
   input  wire logic [FRAC_W-1:0] req_sat_frac,
   input  wire logic [FRAC_W-1:0] req_val_frac,

   // color out
   output logic                   rsp_valid,
   output logic [CHAN_W-1:0]      rsp_red,
   output logic [CHAN_W-1:0]      rsp_green,
   output logic [CHAN_W-1:0]      rsp_blue,
   output logic [CHAN_W-1:0]      rsp_alpha
);

   logic     accept;
   s1_type   s1;
   term_type terms;

   // only reset holds off new pixels
   assign busy   = reset;
   assign accept = start & ~busy;

   // stage one: clamp, sector, v*s
   hsv2rgb_sector u_sector (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .hue    (req_hue_deg_q6),
      .sat    (req_sat_frac),
      .val    (req_val_frac),
      .s1     (s1)
   );

   // stages two and three: x term, m offset, channel sums
   hsv2rgb_chroma u_chroma (
      .clock (clock),
      .reset (reset),
      .s1    (s1),
      .terms (terms)
   );

   // stage four: 8-bit channels into output registers
   hsv2rgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .terms     (terms),
      .out_valid (rsp_valid),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

   // fully opaque
   assign rsp_alpha = ALPHA_OPAQUE;

endmodule

`default_nettype wire

### hdl/hsv2rgb_checker.sv
// port-level checks of the hsv to rgb converter and their bind
`default_nettype none

`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [15:0] req_hue_deg_q6,
   input wire logic [8:0]  req_sat_frac,
   input wire logic [8:0]  req_val_frac,
   input wire logic        rsp_valid,
   input wire logic [7:0]  rsp_red,
   input wire logic [7:0]  rsp_green,
   input wire logic [7:0]  rsp_blue,
   input wire logic [7:0]  rsp_alpha
);

   logic taken;

   assign taken = start & ~busy;

   // every taken pixel gives a result beat
   `HSV2RGB_ASSERT_NEXT(a_latency, clock, reset, taken, ##3 rsp_valid)

   // no result beat without a matching pixel taken earlier
   `HSV2RGB_ASSERT_IMPL(a_no_spurious, clock, reset, rsp_valid, $past(taken, 4))

   // zero saturation or out-of-range hue gives grey
   `HSV2RGB_ASSERT_IMPL(a_grey, clock, reset, rsp_valid && $past(taken && ((req_sat_frac == 9'd0) || (req_hue_deg_q6 >= 16'd23040)), 4), (rsp_red == rsp_green) && (rsp_green == rsp_blue))

   // alpha is opaque on every result beat
   `HSV2RGB_ASSERT_IMPL(a_alpha, clock, reset, rsp_valid, rsp_alpha == 8'hFF)

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (.*);

`default_nettype wire
